// ----- rtl/median_filter_window_defines.svh -----
// Assertion macros for the median filter window block.
`ifndef MEDIAN_FILTER_WINDOW_DEFINES_SVH
`define MEDIAN_FILTER_WINDOW_DEFINES_SVH
`ifndef SYNTHESIS
`define MFW_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define MFW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define MFW_ASSERT_SAME(label, clk, rst, ante, cons)
`define MFW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/mfw_pkg.sv -----
// Shared constants, types and state codes of the median filter window.
`default_nettype none
package mfw_pkg;
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 4096;
   localparam int RADIUS      = 7;
   localparam int STORE_ROWS  = 2 * RADIUS + 1;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int SLOT_W      = $clog2(STORE_ROWS);
   localparam int ADDR_W      = SLOT_W + COL_W;
   localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH;
   localparam int PIX_W       = 24;
   localparam int POS_W       = 23;
   localparam int WIDTH_W     = 11;
   localparam int HEIGHT_W    = 13;
   localparam int LAG_W       = 13;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 13;
   localparam int CNT_W       = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd500;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd500;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIZE,
      ST_EVAL,
      ST_SCAN,
      ST_LAST,
      ST_DECIDE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       init;
      logic       sample;
      logic       decide;
      logic [2:0] bit_idx;
   } sel_ctl_type;
endpackage
`default_nettype wire

// ----- rtl/mfw_ram.sv -----
// Single-port synchronous RAM with registered read data.
`default_nettype none
module mfw_ram #(
   parameter int ADDR_W = 14,
   parameter int DATA_W = 24,
   parameter int DEPTH  = 15360
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [DATA_W-1:0] wdata,
   output logic      [DATA_W-1:0] rdata
);
   logic [DATA_W-1:0] mem [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

// ----- rtl/mfw_rank_sel.sv -----
// Bit-serial selection of the two middle ranks of one channel's window.
`default_nettype none
module mfw_rank_sel import mfw_pkg::*; (
   input  wire logic              clock,
   input  wire sel_ctl_type       ctl,
   input  wire logic [7:0]        sample,
   input  wire logic [CNT_W-1:0]  k_lo,
   input  wire logic [CNT_W-1:0]  k_hi,
   output logic      [7:0]        median
);
   logic [CNT_W-1:0] k_ff      [2];
   logic [CNT_W-1:0] k_in      [2];
   logic [7:0]       prefix_ff [2];
   logic [7:0]       prefix_in [2];
   logic [CNT_W-1:0] count_ff  [2];
   logic [CNT_W-1:0] count_in  [2];
   logic [7:0]       hi_mask;
   logic [1:0]       hit;

   always_comb begin
      hi_mask = ~((8'd2 << ctl.bit_idx) - 8'd1);
      for (int i = 0; i < 2; i++) begin
         hit[i] = ((((sample ^ prefix_ff[i]) & hi_mask) == 8'd0) && !sample[ctl.bit_idx]);
         k_in[i]      = k_ff[i];
         prefix_in[i] = prefix_ff[i];
         count_in[i]  = count_ff[i];
         if (ctl.init) begin
            k_in[i]      = (i == 0) ? k_lo : k_hi;
            prefix_in[i] = 8'd0;
            count_in[i]  = '0;
         end else if (ctl.sample) begin
            if (hit[i]) begin
               count_in[i] = count_ff[i] + CNT_W'(1);
            end
         end else if (ctl.decide) begin
            if (count_ff[i] <= k_ff[i]) begin
               prefix_in[i][ctl.bit_idx] = 1'b1;
               k_in[i] = k_ff[i] - count_ff[i];
            end
            count_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      prefix_ff <= prefix_in;
      count_ff  <= count_in;
   end

   assign median = 8'((9'(prefix_ff[0]) + 9'(prefix_ff[1])) >> 1);
endmodule
`default_nettype wire

// ----- rtl/median_filter_window.sv -----
// Top level of the streaming 15x15 median filter with frame-edge clipping.
//
// Input transactions (req_) carry one pixel of three 8-bit channels, or a
// drain marker once a frame's pixels are all in. Result transactions (rsp_)
// carry the per-channel window median and a frame_end flag on the last
// result of the frame. Results trail the input by 7 rows plus 7 pixels.
// The csr_ port sets frame width and height; a frame keeps the size seen
// at its first transaction.
// One input transaction is taken at a time. For one with a result, the
// median of the clipped window (up to 225 pixels) is found one bit per
// pass, eight passes, each reading the window through the single read
// port of the row memory.
// The result register frees the input side while a result waits; under
// rsp_stall a finished result holds, and a second one waits in the block.
// Reset sets the size to 500 x 500 and the frame position to zero. The
// row memory is not cleared; windows only read pixels already written.
`default_nettype none
`include "median_filter_window_defines.svh"
module median_filter_window import mfw_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_ch0_in,
   input  wire logic [7:0]            req_ch1_in,
   input  wire logic [7:0]            req_ch2_in,
   input  wire logic                  req_drain,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [7:0]            rsp_ch0_out,
   output logic      [7:0]            rsp_ch1_out,
   output logic      [7:0]            rsp_ch2_out,
   output logic                       rsp_frame_end,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);
   state_type            state_ff, state_in;
   logic [WIDTH_W-1:0]   width_ff, width_in;
   logic [HEIGHT_W-1:0]  height_ff, height_in;
   logic [WIDTH_W-1:0]   cur_w_ff, cur_w_in;
   logic [HEIGHT_W-1:0]  cur_h_ff, cur_h_in;
   logic [POS_W-1:0]     total_ff, total_in;
   logic [LAG_W-1:0]     lag_ff, lag_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [COL_W-1:0]     pcol_ff, pcol_in;
   logic [SLOT_W-1:0]    pslot_ff, pslot_in;
   logic [COL_W-1:0]     ocol_ff, ocol_in;
   logic [ROW_W-1:0]     orow_ff, orow_in;
   logic [SLOT_W-1:0]    oslot_ff, oslot_in;
   logic [PIX_W-1:0]     px_ff, px_in;
   logic                 drain_ff, drain_in;
   logic                 fe_ff, fe_in;
   logic [SLOT_W-1:0]    first_slot_ff, first_slot_in;
   logic [SLOT_W-1:0]    nrow_ff, nrow_in;
   logic [COL_W-1:0]     c_lo_ff, c_lo_in;
   logic [COL_W-1:0]     c_hi_ff, c_hi_in;
   logic [SLOT_W-1:0]    rslot_ff, rslot_in;
   logic [SLOT_W-1:0]    rleft_ff, rleft_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [2:0]           bit_ff, bit_in;
   logic                 rd_valid_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_ch0_ff, rsp_ch1_ff, rsp_ch2_ff;
   logic                 rsp_fe_ff;
   logic                 rsp_load;

   logic [WIDTH_W-1:0]   w_clamp;
   logic [HEIGHT_W-1:0]  h_clamp;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_addr;
   logic [PIX_W-1:0]     mem_rdata;
   logic                 store;
   logic                 produce;
   logic                 last_out;
   logic [ROW_W-1:0]     r_lo, r_hi;
   logic [COL_W-1:0]     c_lo, c_hi;
   logic [SLOT_W-1:0]    nr, nc;
   logic [CNT_W-1:0]     n_win;
   logic [CNT_W-1:0]     k_lo, k_hi;
   logic [SLOT_W-1:0]    start_slot;
   sel_ctl_type          sel_ctl;
   logic [7:0]           med0, med1, med2;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = WIDTH_W'(csr_wdata);
            CSR_FRAME_HEIGHT: height_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_clamp = WIDTH_W'(1);
      end else if (width_ff > WIDTH_W'(MAX_WIDTH)) begin
         w_clamp = WIDTH_W'(MAX_WIDTH);
      end else begin
         w_clamp = width_ff;
      end
      if (height_ff == '0) begin
         h_clamp = HEIGHT_W'(1);
      end else if (height_ff > HEIGHT_W'(MAX_HEIGHT)) begin
         h_clamp = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         h_clamp = height_ff;
      end
   end

   always_comb begin
      store    = (pos_ff < total_ff);
      produce  = (pos_ff >= POS_W'(lag_ff));
      last_out = (13'(orow_ff) == cur_h_ff - 13'd1) && (11'(ocol_ff) == cur_w_ff - 11'd1);
      r_lo = (orow_ff >= ROW_W'(RADIUS)) ? orow_ff - ROW_W'(RADIUS) : '0;
      r_hi = (13'(orow_ff) + 13'(RADIUS) < cur_h_ff) ? orow_ff + ROW_W'(RADIUS)
                                                     : ROW_W'(cur_h_ff - 13'd1);
      c_lo = (ocol_ff >= COL_W'(RADIUS)) ? ocol_ff - COL_W'(RADIUS) : '0;
      c_hi = (11'(ocol_ff) + 11'(RADIUS) < cur_w_ff) ? ocol_ff + COL_W'(RADIUS)
                                                     : COL_W'(cur_w_ff - 11'd1);
      nr    = SLOT_W'(r_hi - r_lo + ROW_W'(1));
      nc    = SLOT_W'(c_hi - c_lo + COL_W'(1));
      n_win = CNT_W'(nr) * CNT_W'(nc);
      k_lo  = (n_win - CNT_W'(1)) >> 1;
      k_hi  = n_win >> 1;
      if (orow_ff < ROW_W'(RADIUS)) begin
         start_slot = '0;
      end else if (oslot_ff >= SLOT_W'(RADIUS)) begin
         start_slot = oslot_ff - SLOT_W'(RADIUS);
      end else begin
         start_slot = oslot_ff + SLOT_W'(STORE_ROWS - RADIUS);
      end
   end

   always_comb begin
      state_in      = state_ff;
      cur_w_in      = cur_w_ff;
      cur_h_in      = cur_h_ff;
      total_in      = total_ff;
      lag_in        = lag_ff;
      pos_in        = pos_ff;
      pcol_in       = pcol_ff;
      pslot_in      = pslot_ff;
      ocol_in       = ocol_ff;
      orow_in       = orow_ff;
      oslot_in      = oslot_ff;
      px_in         = px_ff;
      drain_in      = drain_ff;
      fe_in         = fe_ff;
      first_slot_in = first_slot_ff;
      nrow_in       = nrow_ff;
      c_lo_in       = c_lo_ff;
      c_hi_in       = c_hi_ff;
      rslot_in      = rslot_ff;
      rleft_in      = rleft_ff;
      col_in        = col_ff;
      bit_in        = bit_ff;
      mem_we        = 1'b0;
      mem_addr      = {rslot_ff, col_ff};
      sel_ctl       = '{init: 1'b0, sample: rd_valid_ff, decide: 1'b0, bit_idx: bit_ff};
      rsp_load      = 1'b0;
      req_stall     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               px_in    = {req_ch2_in, req_ch1_in, req_ch0_in};
               drain_in = req_drain;
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            if (pos_ff == '0) begin
               cur_w_in = w_clamp;
               cur_h_in = h_clamp;
            end
            total_in = POS_W'(24'(cur_w_in) * 24'(cur_h_in));
            lag_in   = LAG_W'(cur_w_in) * LAG_W'(RADIUS) + LAG_W'(RADIUS);
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (store && drain_ff) begin
               state_in = ST_IDLE;
            end else begin
               if (store) begin
                  mem_we   = 1'b1;
                  mem_addr = {pslot_ff, pcol_ff};
                  if (11'(pcol_ff) == cur_w_ff - 11'd1) begin
                     pcol_in  = '0;
                     pslot_in = (pslot_ff == SLOT_W'(STORE_ROWS - 1)) ? '0
                                                                      : pslot_ff + SLOT_W'(1);
                  end else begin
                     pcol_in = pcol_ff + COL_W'(1);
                  end
               end
               pos_in = pos_ff + POS_W'(1);
               if (!produce) begin
                  state_in = ST_IDLE;
               end else begin
                  fe_in         = last_out;
                  first_slot_in = start_slot;
                  nrow_in       = nr;
                  c_lo_in       = c_lo;
                  c_hi_in       = c_hi;
                  rslot_in      = start_slot;
                  rleft_in      = nr - SLOT_W'(1);
                  col_in        = c_lo;
                  bit_in        = 3'd7;
                  sel_ctl.init  = 1'b1;
                  if (last_out) begin
                     pos_in   = '0;
                     pcol_in  = '0;
                     pslot_in = '0;
                     ocol_in  = '0;
                     orow_in  = '0;
                     oslot_in = '0;
                  end else if (11'(ocol_ff) == cur_w_ff - 11'd1) begin
                     ocol_in  = '0;
                     orow_in  = orow_ff + ROW_W'(1);
                     oslot_in = (oslot_ff == SLOT_W'(STORE_ROWS - 1)) ? '0
                                                                      : oslot_ff + SLOT_W'(1);
                  end else begin
                     ocol_in = ocol_ff + COL_W'(1);
                  end
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (col_ff == c_hi_ff) begin
               col_in = c_lo_ff;
               if (rleft_ff == '0) begin
                  state_in = ST_LAST;
               end else begin
                  rleft_in = rleft_ff - SLOT_W'(1);
                  rslot_in = (rslot_ff == SLOT_W'(STORE_ROWS - 1)) ? '0
                                                                   : rslot_ff + SLOT_W'(1);
               end
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         ST_LAST: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            sel_ctl.decide = 1'b1;
            if (bit_ff == 3'd0) begin
               state_in = ST_OUT;
            end else begin
               bit_in   = bit_ff - 3'd1;
               rslot_in = first_slot_ff;
               rleft_in = nrow_ff - SLOT_W'(1);
               col_in   = c_lo_ff;
               state_in = ST_SCAN;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         cur_w_ff     <= WIDTH_RESET;
         cur_h_ff     <= HEIGHT_RESET;
         total_ff     <= '0;
         lag_ff       <= '0;
         pos_ff       <= '0;
         pcol_ff      <= '0;
         pslot_ff     <= '0;
         ocol_ff      <= '0;
         orow_ff      <= '0;
         oslot_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         cur_w_ff     <= cur_w_in;
         cur_h_ff     <= cur_h_in;
         total_ff     <= total_in;
         lag_ff       <= lag_in;
         pos_ff       <= pos_in;
         pcol_ff      <= pcol_in;
         pslot_ff     <= pslot_in;
         ocol_ff      <= ocol_in;
         orow_ff      <= orow_in;
         oslot_ff     <= oslot_in;
         rd_valid_ff  <= (state_ff == ST_SCAN);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff         <= px_in;
      drain_ff      <= drain_in;
      fe_ff         <= fe_in;
      first_slot_ff <= first_slot_in;
      nrow_ff       <= nrow_in;
      c_lo_ff       <= c_lo_in;
      c_hi_ff       <= c_hi_in;
      rslot_ff      <= rslot_in;
      rleft_ff      <= rleft_in;
      col_ff        <= col_in;
      bit_ff        <= bit_in;
      if (rsp_load) begin
         rsp_ch0_ff <= med0;
         rsp_ch1_ff <= med1;
         rsp_ch2_ff <= med2;
         rsp_fe_ff  <= fe_ff;
      end
   end

   mfw_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (PIX_W),
      .DEPTH  (STORE_DEPTH)
   ) u_row_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (px_ff),
      .rdata (mem_rdata)
   );

   mfw_rank_sel u_sel0 (
      .clock  (clock),
      .ctl    (sel_ctl),
      .sample (mem_rdata[7:0]),
      .k_lo   (k_lo),
      .k_hi   (k_hi),
      .median (med0)
   );

   mfw_rank_sel u_sel1 (
      .clock  (clock),
      .ctl    (sel_ctl),
      .sample (mem_rdata[15:8]),
      .k_lo   (k_lo),
      .k_hi   (k_hi),
      .median (med1)
   );

   mfw_rank_sel u_sel2 (
      .clock  (clock),
      .ctl    (sel_ctl),
      .sample (mem_rdata[23:16]),
      .k_lo   (k_lo),
      .k_hi   (k_hi),
      .median (med2)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ch0_out   = rsp_ch0_ff;
   assign rsp_ch1_out   = rsp_ch1_ff;
   assign rsp_ch2_out   = rsp_ch2_ff;
   assign rsp_frame_end = rsp_fe_ff;

   `MFW_ASSERT_NEXT(a_accept_holds_off, clock, reset, req_valid && !req_stall, req_stall)
   `MFW_ASSERT_SAME(a_frame_start_clean, clock, reset, pos_ff == '0,
      pcol_ff == '0 && ocol_ff == '0 && orow_ff == '0)
   `MFW_ASSERT_SAME(a_scan_in_window, clock, reset, state_ff == ST_SCAN,
      col_ff >= c_lo_ff && col_ff <= c_hi_ff)
endmodule
`default_nettype wire
